// ===== hdl/fee_pkg.sv =====
// ----------------------------------------------------------------------------
// fee_pkg: shared types and helpers for the filename escape encoder
// Holds the character constants, the queue entry type and the class code
// lookup used by the front end.
// ----------------------------------------------------------------------------
package fee_pkg;

  // expansion of one byte: up to four body characters plus a trailing dot
  localparam int unsigned MaxChars = 5;
  localparam int unsigned CntW     = $clog2(MaxChars + 1);
  localparam int unsigned IdxW     = $clog2(MaxChars);

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChDot    = 8'h2e;
  localparam logic [7:0] ChDash   = 8'h2d;
  localparam logic [7:0] ChUnder  = 8'h5f;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpB    = 8'h42;
  localparam logic [7:0] ChUpZ    = 8'h5a;
  localparam logic [7:0] ChLoA    = 8'h61;
  localparam logic [7:0] ChLoZ    = 8'h7a;
  localparam logic [7:0] ChFour   = 8'h34;
  localparam logic [7:0] ChFive   = 8'h35;
  localparam logic [7:0] ChSix    = 8'h36;
  localparam logic [7:0] ChSeven  = 8'h37;
  localparam logic [7:0] ChEight  = 8'h38;
  localparam logic [7:0] CaseDiff = 8'd32;

  // one classified byte, ready to be sent out character by character
  typedef struct packed {
    logic [MaxChars-1:0][7:0] chars;
    logic [CntW-1:0]          count;
    logic                     last;
  } fee_entry_t;

  // two-character class code for a byte below 0200, first character on top
  function automatic logic [15:0] fee_class(input logic [7:0] c);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = ChNine;
    lo = ChUpA;
    if (c == 8'd0) begin
      hi = ChSix;   lo = ChUpA;
    end else if (c <= 8'd26) begin
      hi = ChFour;  lo = ChUpA + (c - 8'd1);
    end else if (c < 8'd32) begin
      hi = ChSix;   lo = ChUpB + (c - 8'd27);
    end else if (c == 8'd32) begin
      hi = ChSeven; lo = ChUpA;
    end else if (c < 8'd58) begin
      hi = ChFive;  lo = ChUpA + (c - 8'd33);
    end else if (c == 8'd58) begin
      hi = ChFive;  lo = ChUpZ;
    end else if (c < 8'd64) begin
      hi = ChSeven; lo = ChUpB + (c - 8'd59);
    end else if (c < 8'd96) begin
      hi = ChEight; lo = ChUpA + (c - 8'd64);
    end else if (c == 8'd96) begin
      hi = ChNine;  lo = ChUpA;
    end else begin
      hi = ChNine;  lo = ChUpB + (c - 8'd122);
    end
    return {hi, lo};
  endfunction

endpackage

// ===== hdl/fee_front.sv =====
// ----------------------------------------------------------------------------
// fee_front: byte classifier
// Accepts raw filename bytes, keeps the per-name state and turns each byte
// into a queue entry holding its whole escaped expansion.
// ----------------------------------------------------------------------------
module fee_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_data_i,
  input  logic               in_valid_i,
  input  logic [7:0]         in_char_i,
  input  logic               in_last_i,
  output logic               in_stall_o,
  input  logic               q_full_i,
  output logic               push_o,
  output fee_pkg::fee_entry_t entry_o
);
  import fee_pkg::*;

  logic dir_mode_q;
  logic case_mode_q, case_mode_d;
  logic dot_kept_q, dot_kept_d;
  logic dot_seen_q, dot_seen_d;

  logic              is_lower, is_upper, is_plain, dot_seen_now;
  logic [3:0][7:0]   body;
  logic [CntW-1:0]   body_n;
  logic              add_dot;
  logic [15:0]       cls;
  logic [7:0]        up_char;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      dir_mode_q <= cfg_data_i;
    end
  end

  // byte classification and body characters
  always_comb begin
    is_lower = (in_char_i >= ChLoA) && (in_char_i <= ChLoZ);
    is_upper = (in_char_i >= ChUpA) && (in_char_i <= ChUpZ);
    is_plain = ((in_char_i >= ChZero) && (in_char_i <= ChNine)) ||
               (in_char_i == ChDash) || (in_char_i == ChUnder);
    up_char  = is_lower ? (in_char_i - CaseDiff) : in_char_i;
    cls      = fee_class(in_char_i);
    case_mode_d = case_mode_q;
    dot_kept_d  = dot_kept_q;
    body   = {4{ChDollar}};
    body_n = CntW'(1);
    if (is_lower || is_upper) begin
      if (is_lower == case_mode_q) begin
        body[0] = ChDollar;
        body[1] = up_char;
        body_n  = CntW'(2);
        case_mode_d = ~case_mode_q;
      end else begin
        body[0] = up_char;
      end
    end else if (is_plain) begin
      body[0] = in_char_i;
    end else if ((in_char_i == ChDot) && !dot_kept_q && !dir_mode_q) begin
      body[0]    = ChDot;
      dot_kept_d = 1'b1;
    end else if (in_char_i == ChDollar) begin
      body_n = CntW'(2);
    end else if (in_char_i[7]) begin
      // high byte: three octal digits
      body[1] = ChZero + {6'd0, in_char_i[7:6]};
      body[2] = ChZero + {5'd0, in_char_i[5:3]};
      body[3] = ChZero + {5'd0, in_char_i[2:0]};
      body_n  = CntW'(4);
    end else begin
      body[1] = cls[15:8];
      body[2] = cls[7:0];
      body_n  = CntW'(3);
    end
    dot_seen_now = dot_seen_q || (in_char_i == ChDot);
    dot_seen_d   = dot_seen_now;
    add_dot      = in_last_i && (!dot_seen_now || dir_mode_q);
    // end of name clears the per-name state
    if (in_last_i) begin
      case_mode_d = 1'b0;
      dot_kept_d  = 1'b0;
      dot_seen_d  = 1'b0;
    end
  end

  // assemble the entry, trailing dot right after the body
  always_comb begin
    for (int k = 0; k < MaxChars; k++) begin
      if (k < 4 && CntW'(k) < body_n) begin
        entry_o.chars[k] = body[k[1:0]];
      end else begin
        entry_o.chars[k] = ChDot;
      end
    end
    entry_o.count = body_n + CntW'(add_dot);
    entry_o.last  = in_last_i;
  end

  // per-name state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      case_mode_q <= 1'b0;
      dot_kept_q  <= 1'b0;
      dot_seen_q  <= 1'b0;
    end else if (push_o) begin
      case_mode_q <= case_mode_d;
      dot_kept_q  <= dot_kept_d;
      dot_seen_q  <= dot_seen_d;
    end
  end

endmodule

// ===== hdl/fee_queue.sv =====
// ----------------------------------------------------------------------------
// fee_queue: two-entry queue
// Decouples the classifier from the serializer so each side stalls on its
// own.
// ----------------------------------------------------------------------------
module fee_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  fee_pkg::fee_entry_t entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output fee_pkg::fee_entry_t head_o
);
  import fee_pkg::*;

  fee_entry_t slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q, fill_d;

  assign full_o  = fill_q[1];
  assign valid_o = (fill_q != 2'd0);
  assign head_o  = slot_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  // fill count
  always_comb begin
    fill_d = fill_q;
    if (push_i && !pop_i) begin
      fill_d = fill_q + 2'd1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 2'd1;
    end
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      fill_q <= fill_d;
    end
  end

endmodule

// ===== hdl/fee_back.sv =====
// ----------------------------------------------------------------------------
// fee_back: character serializer
// Walks the head queue entry one character per cycle, while the output is not
// stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module fee_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  fee_pkg::fee_entry_t head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  output logic [7:0]          out_char_o,
  output logic                out_last_o,
  input  logic                out_stall_i
);
  import fee_pkg::*;

  logic [IdxW-1:0] idx_q, idx_d;
  logic            valid_q, valid_d;
  logic [7:0]      char_q;
  logic            last_q;
  logic            load, at_end;

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;

  // advance through the head entry
  always_comb begin
    load    = q_valid_i && (!valid_q || !out_stall_i);
    at_end  = (CntW'(idx_q) + CntW'(1)) == head_i.count;
    pop_o   = load && at_end;
    idx_d   = idx_q;
    valid_d = valid_q && out_stall_i;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = at_end ? '0 : idx_q + IdxW'(1);
    end
  end

  // output transaction register
  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= head_i.chars[idx_q];
      last_q <= head_i.last && at_end;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

endmodule

// ===== hdl/filename_escape_encoder.sv =====
// ----------------------------------------------------------------------------
// filename_escape_encoder: case-sensitive filename to escaped name
// Top level joining the classifier, the entry queue and the serializer.
// ----------------------------------------------------------------------------
// One input transaction carries one filename byte; it expands to one to
// five output transactions of one character each (at most five: a
// four-character escape plus the trailing dot), sent at one character
// per cycle while the output is not stalled. The classifier builds each
// byte's queue entry combinationally, and a two-entry queue between it and
// the serializer lets input and output stall independently. dir_mode is
// written through cfg_we_i / cfg_data_i; the user must write it only while
// the block is idle, as the block itself does not enforce this.
module filename_escape_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_data_i,
  input  logic       in_valid_i,
  input  logic [7:0] in_char_i,
  input  logic       in_last_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  output logic [7:0] out_char_o,
  output logic       out_last_o,
  input  logic       out_stall_i
);
  import fee_pkg::*;

  fee_entry_t push_entry, head_entry;
  logic       push, q_full, q_valid, pop;

  // byte classifier
  fee_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_char_i  (in_char_i),
    .in_last_i  (in_last_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  // entry queue
  fee_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .head_o  (head_entry)
  );

  // character serializer
  fee_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .head_i      (head_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_char_o  (out_char_o),
    .out_last_o  (out_last_o),
    .out_stall_i (out_stall_i)
  );

endmodule

// ===== tb/filename_escape_encoder_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// filename_escape_encoder_test: self-checking bench for the escape encoder
// Feeds filename bytes, first from a short directed table and then as random
// names, idling one or both channels at random. Output characters are checked
// against typed row text or an in-bench model that tracks case mode and dots.
// ----------------------------------------------------------------------------
module filename_escape_encoder_test;
  import fee_pkg::*;

  localparam int unsigned QuietLimit = 1000;
  localparam int unsigned LongHold   = 150;
  localparam int unsigned PhaseItems = 35;
  localparam int unsigned NumPhases  = 6;

  typedef struct packed {
    logic [7:0] ch;
    logic       lst;
  } out_char_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       lst;
    logic       dir;
  } dir_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_data_i;
  logic       in_valid_i;
  logic [7:0] in_char_i;
  logic       in_last_i;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] out_char_o;
  logic       out_last_o;
  logic       out_stall_i;

  // encoder model state and its copy of the register
  logic cfg_dir;
  logic st_case;
  logic st_dot_kept;
  logic st_dot_seen;

  logic [7:0] esc_chars[$];
  out_char_t  pending_chars[$];

  // directed table and the typed expectation for the byte on the bus
  dir_row_t tab_q[$];
  string    txt_q[$];
  string    cur_txt;

  // receiver control, written at rising edges and read at falling edges
  int rx_mode;
  int hold_req;

  logic dir_set;
  int   n_err;
  int   n_shown;
  int   n_in;
  int   n_out;
  int   n_names;
  int   n_flips;
  int   quiet;

  filename_escape_encoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_char_i   (in_char_i),
    .in_last_i   (in_last_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_char_o  (out_char_o),
    .out_last_o  (out_last_o),
    .out_stall_i (out_stall_i)
  );

  // clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // two-character class code of a byte, or three octal digits for high bytes
  function automatic void push_class(input logic [7:0] c);
    if (c == 8'd0) begin
      esc_chars.push_back("6"); esc_chars.push_back("A");
    end else if (c <= 8'd26) begin
      esc_chars.push_back("4"); esc_chars.push_back(ChUpA + (c - 8'd1));
    end else if (c < 8'd32) begin
      esc_chars.push_back("6"); esc_chars.push_back(ChUpB + (c - 8'd27));
    end else if (c == 8'd32) begin
      esc_chars.push_back("7"); esc_chars.push_back("A");
    end else if (c < 8'd58) begin
      esc_chars.push_back("5"); esc_chars.push_back(ChUpA + (c - 8'd33));
    end else if (c == 8'd58) begin
      esc_chars.push_back("5"); esc_chars.push_back("Z");
    end else if (c < 8'd64) begin
      esc_chars.push_back("7"); esc_chars.push_back(ChUpB + (c - 8'd59));
    end else if (c < 8'd96) begin
      esc_chars.push_back("8"); esc_chars.push_back(ChUpA + (c - 8'd64));
    end else if (c == 8'd96) begin
      esc_chars.push_back("9"); esc_chars.push_back("A");
    end else if (c < 8'd128) begin
      esc_chars.push_back("9"); esc_chars.push_back(ChUpB + (c - 8'd122));
    end else begin
      esc_chars.push_back(ChZero + {6'd0, c[7:6]});
      esc_chars.push_back(ChZero + {5'd0, c[5:3]});
      esc_chars.push_back(ChZero + {5'd0, c[2:0]});
    end
  endfunction

  // escaped characters of one byte, updating case and dot state
  function automatic void encode_byte(input logic [7:0] c, input logic lst);
    logic is_lo;
    logic is_up;
    is_lo = (c >= ChLoA) && (c <= ChLoZ);
    is_up = (c >= ChUpA) && (c <= ChUpZ);
    esc_chars.delete();
    if (is_lo || is_up) begin
      if (is_lo == st_case) begin
        esc_chars.push_back(ChDollar);
        st_case = ~st_case;
      end
      esc_chars.push_back(is_lo ? c - CaseDiff : c);
    end else if ((c >= ChZero && c <= ChNine) || c == ChDash || c == ChUnder) begin
      esc_chars.push_back(c);
    end else if (c == ChDot && !st_dot_kept && !cfg_dir) begin
      esc_chars.push_back(ChDot);
      st_dot_kept = 1'b1;
    end else if (c == ChDollar) begin
      esc_chars.push_back(ChDollar);
      esc_chars.push_back(ChDollar);
    end else begin
      esc_chars.push_back(ChDollar);
      push_class(c);
    end
    if (c == ChDot) st_dot_seen = 1'b1;
    // end of name: trailing dot and a fresh state for the next name
    if (lst) begin
      if (!st_dot_seen || cfg_dir) esc_chars.push_back(ChDot);
      st_case     = 1'b0;
      st_dot_kept = 1'b0;
      st_dot_seen = 1'b0;
    end
  endfunction

  // scoreboard: predict on input transactions, check output transactions
  always @(posedge clk_i) begin
    out_char_t e;
    if (rst_ni) begin
      if (cfg_we_i) cfg_dir = cfg_data_i;
      if (in_valid_i && !in_stall_o) begin
        encode_byte(in_char_i, in_last_i);
        if (cur_txt.len() > 0) begin
          esc_chars.delete();
          for (int i = 0; i < cur_txt.len(); i++) esc_chars.push_back(cur_txt[i]);
        end
        for (int i = 0; i < esc_chars.size(); i++) begin
          e.ch  = esc_chars[i];
          e.lst = in_last_i && (i == esc_chars.size() - 1);
          pending_chars.push_back(e);
        end
        n_in++;
        if (in_last_i) n_names++;
      end
      if (out_valid_o && !out_stall_i) begin
        n_out++;
        if (pending_chars.size() == 0) begin
          n_err++;
          if (n_shown < 10)
            $display("unexpected output char %h last %b", out_char_o, out_last_o);
          n_shown++;
        end else begin
          e = pending_chars.pop_front();
          if (e.ch !== out_char_o || e.lst !== out_last_o) begin
            n_err++;
            if (n_shown < 10)
              $display("mismatch at output %0d: expected char %h last %b, got char %h last %b",
                       n_out, e.ch, e.lst, out_char_o, out_last_o);
            n_shown++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QuietLimit) begin
      $display("timeout: no transaction for %0d cycles", quiet);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: random hold-offs, plus one long hold on request
  initial begin
    int r;
    int rx_left;
    out_stall_i = 1'b0;
    rx_left     = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req != 0) begin
        hold_req = 0;
        rx_left  = LongHold;
      end
      if (rx_left > 0) begin
        out_stall_i = 1'b1;
        rx_left--;
      end else if (rx_mode == 0) begin
        out_stall_i = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_stall_i = 1'b0;
        end else if (r < 95) begin
          out_stall_i = 1'b1;
          rx_left     = $urandom_range(0, 2);
        end else begin
          out_stall_i = 1'b1;
          rx_left     = $urandom_range(10, 40);
        end
      end
    end
  end

  function automatic int pick_gap(input bit idle_on);
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // random filename byte, weighted toward the interesting classes
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return 8'($urandom_range(ChLoA, ChLoZ));
    if (r < 45) return 8'($urandom_range(ChUpA, ChUpZ));
    if (r < 55) return 8'($urandom_range(ChZero, ChNine));
    if (r < 58) return ChDash;
    if (r < 61) return ChUnder;
    if (r < 70) return ChDot;
    if (r < 74) return ChDollar;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void add_row(input logic [7:0] ch, input logic lst, input logic dir,
                                  input string txt);
    tab_q.push_back('{ch: ch, lst: lst, dir: dir});
    txt_q.push_back(txt);
  endfunction

  // offer one byte after a gap and wait for its transaction; ends at a falling edge
  task automatic offer(input logic [7:0] ch, input logic lst, input string txt, input int gap);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_char_i  = ch;
    in_last_i  = lst;
    cur_txt    = txt;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (pending_chars.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // register write while the block is idle
  task automatic write_dir(input logic v);
    drain();
    cfg_we_i   = 1'b1;
    cfg_data_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (v != dir_set) n_flips++;
    dir_set = v;
  endtask

  task automatic set_rx(input int mode, input int hold);
    @(posedge clk_i);
    rx_mode  = mode;
    hold_req = hold;
    @(negedge clk_i);
  endtask

  // stimulus
  initial begin
    int   len;
    int   flip_at;
    int   ph_items;
    bit   tx_idle;
    logic ph_dir;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_data_i  = 1'b0;
    in_valid_i  = 1'b0;
    in_char_i   = 8'h00;
    in_last_i   = 1'b0;
    cur_txt     = "";
    rx_mode     = 1;
    hold_req    = 0;
    cfg_dir     = 1'b0;
    st_case     = 1'b0;
    st_dot_kept = 1'b0;
    st_dot_seen = 1'b0;
    dir_set     = 1'b0;
    n_err       = 0;
    n_shown     = 0;
    n_in        = 0;
    n_out       = 0;
    n_names     = 0;
    n_flips     = 0;
    quiet       = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    write_dir(1'b0);

    // directed table: empty text means the model decides
    add_row(8'h61, 1'b0, 1'b0, "A");
    add_row(8'h42, 1'b0, 1'b0, "$B");
    add_row(8'h63, 1'b0, 1'b0, "");
    add_row(8'h00, 1'b0, 1'b0, "$6A");
    add_row(8'hff, 1'b0, 1'b0, "$377");
    add_row(8'h2e, 1'b0, 1'b0, ".");
    add_row(8'h2e, 1'b0, 1'b0, "");
    add_row(8'h24, 1'b0, 1'b0, "$$");
    add_row(8'h30, 1'b0, 1'b0, "");
    add_row(8'h39, 1'b0, 1'b0, "");
    add_row(8'h2d, 1'b0, 1'b0, "");
    add_row(8'h5f, 1'b0, 1'b0, "");
    add_row(8'h3a, 1'b0, 1'b0, "");
    add_row(8'h3b, 1'b0, 1'b0, "");
    add_row(8'h40, 1'b0, 1'b0, "");
    add_row(8'h60, 1'b0, 1'b0, "");
    add_row(8'h7b, 1'b0, 1'b0, "");
    add_row(8'h7f, 1'b0, 1'b0, "");
    add_row(8'h80, 1'b0, 1'b0, "");
    add_row(8'h20, 1'b0, 1'b0, "");
    add_row(8'h1b, 1'b0, 1'b0, "");
    add_row(8'h1a, 1'b0, 1'b0, "");
    add_row(8'h7a, 1'b1, 1'b0, "");
    add_row(8'h5a, 1'b1, 1'b0, "$Z.");
    add_row(8'h2e, 1'b1, 1'b1, "");
    add_row(8'h61, 1'b1, 1'b1, "A.");
    for (int i = 0; i < tab_q.size(); i++) begin
      if (tab_q[i].dir != dir_set) write_dir(tab_q[i].dir);
      offer(tab_q[i].ch, tab_q[i].lst, txt_q[i], pick_gap(1'b1));
    end

    // random names in phases of different register and idling settings
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0:       ph_dir = 1'b0;
        1, 2:    ph_dir = 1'b1;
        3:       ph_dir = 1'b0;
        default: ph_dir = 1'($urandom_range(0, 1));
      endcase
      tx_idle = (ph != 1) && (ph != 3);
      write_dir(ph_dir);
      // phase one: long output hold with the sender pushing at full rate
      set_rx((ph == 2 || ph == 5) ? 0 : 1, (ph == 1) ? 1 : 0);
      ph_items = 0;
      while (ph_items < PhaseItems) begin
        len     = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 16);
        flip_at = (len > 2 && $urandom_range(0, 9) == 0) ? len / 2 : -1;
        for (int k = 0; k < len; k++) begin
          // register change in the middle of a name
          if (k == flip_at) write_dir(~dir_set);
          offer(pick_char(), k == len - 1, "", pick_gap(tx_idle));
          ph_items++;
        end
      end
    end

    drain();
    repeat (10) @(negedge clk_i);
    $display("encoded %0d bytes in %0d names, checked %0d output characters",
             n_in, n_names, n_out);
    $display("directory mode changed %0d times, incl. mid-name; one %0d-cycle output hold",
             n_flips, LongHold);
    if (n_err == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", n_err);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filename_escape_encoder.f =====
hdl/fee_pkg.sv
hdl/fee_front.sv
hdl/fee_queue.sv
hdl/fee_back.sv
hdl/filename_escape_encoder.sv
tb/filename_escape_encoder_test.sv
